@@ rtl/ptde_pkg.sv @@
// Piece table descriptor engine: shared types, constants and codes.
// Used by the top level and the checker; depends on nothing.
package ptde_pkg;
	localparam int MaxPieces = 64;
	localparam int PosBits = 32;
	localparam int IdxBits = $clog2(MaxPieces);
	localparam int CntBits = IdxBits + 1;
	localparam int EntryBits = 2 * PosBits + 1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_ERASE  = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_POS  = 2'd1,
		ST_LEN  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [PosBits-1:0] position;
		logic [PosBits-1:0] count;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               from_add_buffer;
		logic [PosBits-1:0] source_offset;
		logic [PosBits-1:0] segment_length;
		logic [PosBits-1:0] document_length;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic               orig;
		logic [PosBits-1:0] off;
		logic [PosBits-1:0] len;
	} entry_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_LOC_RD, S_LOC_WT, S_LOC_EV, S_PREV_WT, S_PLAN,
		S_SH_RD, S_SH_WT, S_SH_WR, S_FIX, S_WR2, S_ER_RD, S_ER_WT, S_ER_EV,
		S_CL_RD, S_CL_WT, S_CL_WR, S_TRIM_RD, S_TRIM_WT, S_TRIM_WR,
		S_RD_RD, S_RD_WT, S_RD_EM, S_RESULT
	} state_t;
endpackage

@@ rtl/piece_table_descriptor_engine.sv @@
// Piece table descriptor engine top level: sequencer, piece memory and output register.
// Depends on ptde_pkg and ptde_ram.
//
// One item is taken at a time; in is not ready until its last result has been
// taken. Locating a position walks the list from the head, one piece at a time
// through the single read port of the piece memory, as does the erase scan; an
// insert moves every later piece up one or two entries (none when it extends the
// previous piece at the end of the add buffer), a split erase moves them up one
// entry, and an erase closes the gap by moving later pieces down. A read gives one
// result per segment and waits on out_ready. Writing the initial length (cfg_we)
// resets the table.
module piece_table_descriptor_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [31:0]              cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  ptde_pkg::in_item_t       in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output ptde_pkg::out_item_t      out_data
);
	import ptde_pkg::*;

	state_t state_q, state_d;
	logic [CntBits-1:0] count_q, count_d;
	logic [PosBits-1:0] fill_q, fill_d, total_q, total_d;
	op_t                op_q, op_d;
	logic [PosBits-1:0] pos_q, pos_d, cnt_q, cnt_d;
	logic [PosBits-1:0] beg_q, beg_d, rem_q, rem_d, off_q, off_d;
	logic [CntBits-1:0] idx_q, idx_d, k_q, k_d, gap_q, gap_d;
	logic [CntBits-1:0] ptr_q, ptr_d;
	logic [1:0]         need_q, need_d;
	entry_t             cur_q, cur_d;
	logic               ext_q, ext_d;
	logic               ov_q, ov_d;
	out_item_t          res_q, res_d;
	logic [1:0]         rst_q, rst_d;

	logic               we;
	logic [IdxBits-1:0] waddr, raddr;
	entry_t             wdata, rdata;

	ptde_ram #(.Width(EntryBits), .Depth(MaxPieces)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			fill_q    <= '0;
			total_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				count_q <= (cfg_wdata != '0) ? CntBits'(1) : '0;
				fill_q  <= '0;
				total_q <= cfg_wdata;
			end else begin
				count_q <= count_d;
				fill_q  <= fill_d;
				total_q <= total_d;
			end
			if ((state_q == S_RESULT || state_q == S_RD_EM) && !(out_valid && !out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d; pos_q <= pos_d; cnt_q <= cnt_d; beg_q <= beg_d;
		rem_q <= rem_d; off_q <= off_d; idx_q <= idx_d; k_q <= k_d;
		gap_q <= gap_d; ptr_q <= ptr_d; need_q <= need_d; cur_q <= cur_d;
		ext_q <= ext_d; ov_q <= ov_d; rst_q <= rst_d; res_q <= res_d;
		if ((state_q == S_RESULT || state_q == S_RD_EM) && !(out_valid && !out_ready)) begin
			out_data <= res_q;
		end
	end

	logic [PosBits:0]   sum_w;
	logic [PosBits-1:0] seg_w;

	always_comb begin
		state_d = state_q; count_d = count_q; fill_d = fill_q; total_d = total_q;
		op_d = op_q; pos_d = pos_q; cnt_d = cnt_q; beg_d = beg_q; rem_d = rem_q;
		off_d = off_q; idx_d = idx_q; k_d = k_q; gap_d = gap_q; ptr_d = ptr_q;
		need_d = need_q; cur_d = cur_q; ext_d = ext_q; ov_d = ov_q; rst_d = rst_q;
		res_d = res_q;
		we = 1'b0; waddr = '0; wdata = '0; raddr = ptr_q[IdxBits-1:0];
		sum_w = '0; seg_w = '0;
		if (cfg_we) begin
			we = 1'b1;
			wdata = '{orig: 1'b1, off: '0, len: cfg_wdata};
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					op_d = op_t'(in_data.operation);
					pos_d = in_data.position;
					cnt_d = in_data.count;
					rst_d = ST_OK;
					ptr_d = '0; beg_d = '0;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_RESULT;
				unique case (op_q) inside
					OP_INSERT: begin
						if (cnt_q == '0) begin
							rst_d = ST_OK;
						end else if (cnt_q > ~total_q) begin
							rst_d = ST_LEN;
						end else if (cnt_q > ~fill_q) begin
							rst_d = ST_FULL;
						end else begin
							state_d = S_LOC_RD;
						end
					end
					OP_ERASE, OP_READ: begin
						if (cnt_q == '0) begin
							rst_d = (op_q == OP_READ && pos_q > total_q) ? ST_POS : ST_OK;
						end else if (pos_q >= total_q) begin
							rst_d = ST_POS;
						end else if (cnt_q > total_q - pos_q) begin
							rst_d = ST_LEN;
						end else begin
							state_d = S_LOC_RD;
						end
					end
					default: rst_d = ST_OK;
				endcase
				res_d = '{status: rst_d, from_add_buffer: 1'b0, source_offset: '0,
					segment_length: '0, document_length: total_q, last: 1'b1};
			end
			S_LOC_RD: begin
				if (ptr_q >= count_q) begin
					idx_d = ptr_q;
					state_d = S_LOC_EV;
				end else begin
					state_d = S_LOC_WT;
				end
			end
			S_LOC_WT: begin
				sum_w = {1'b0, beg_q} + {1'b0, rdata.len};
				if (sum_w > {1'b0, pos_q}) begin
					idx_d = ptr_q;
					cur_d = rdata;
					state_d = S_LOC_EV;
				end else begin
					beg_d = sum_w[PosBits-1:0];
					ptr_d = ptr_q + 1'b1;
					state_d = S_LOC_RD;
				end
			end
			S_LOC_EV: begin
				off_d = (idx_q < count_q) ? pos_q - beg_q : '0;
				unique case (op_q)
					OP_INSERT: begin
						if (idx_q < count_q && off_d != '0) begin
							need_d = 2'd2;
							ext_d = 1'b0;
							state_d = S_PLAN;
						end else if (idx_q == '0) begin
							need_d = 2'd1;
							ext_d = 1'b0;
							state_d = S_PLAN;
						end else begin
							ptr_d = idx_q - 1'b1;
							state_d = S_PREV_WT;
						end
					end
					OP_ERASE: begin
						rem_d = cnt_q;
						state_d = S_ER_EV;
					end
					default: begin
						rem_d = cnt_q;
						k_d = '0;
						state_d = S_RD_RD;
					end
				endcase
			end
			S_PREV_WT: begin
				// waits for the read of the previous piece issued in S_LOC_EV
				state_d = S_PLAN;
				ext_d = 1'b1;
				need_d = 2'd0;
			end
			S_PLAN: begin
				if (ext_q) begin
					sum_w = {1'b0, rdata.off} + {1'b0, rdata.len};
					cur_d = rdata;
					if (!(!rdata.orig && sum_w[PosBits-1:0] == fill_q)) begin
						need_d = 2'd1;
					end
				end
				ext_d = 1'b0;
				if (32'(count_q) + 32'(need_d) > 32'(MaxPieces)) begin
					rst_d = ST_FULL;
					res_d.status = ST_FULL;
					state_d = S_RESULT;
				end else if (need_d == 2'd0) begin
					we = 1'b1;
					waddr = ptr_q[IdxBits-1:0];
					wdata = '{orig: cur_d.orig, off: cur_d.off, len: cur_d.len + cnt_q};
					state_d = S_FIX;
				end else begin
					gap_d = CntBits'(need_d);
					k_d = (need_d == 2'd2) ? idx_q + 1'b1 : idx_q;
					ptr_d = count_q;
					state_d = S_SH_RD;
				end
			end
			S_SH_RD: begin
				if (ptr_q <= k_q) begin
					state_d = S_WR2;
					need_d = need_q;
				end else begin
					ptr_d = ptr_q - 1'b1;
					state_d = S_SH_WT;
				end
			end
			S_SH_WT: begin
				raddr = ptr_q[IdxBits-1:0];
				state_d = S_SH_WR;
			end
			S_SH_WR: begin
				we = 1'b1;
				waddr = IdxBits'(ptr_q + gap_q);
				wdata = rdata;
				state_d = S_SH_RD;
			end
			S_WR2: begin
				we = 1'b1;
				if (need_q == 2'd2) begin
					if (op_q == OP_ERASE) begin
						waddr = IdxBits'(idx_q + 1'b1);
						wdata = '{orig: cur_q.orig, off: cur_q.off + off_q + cnt_q,
							len: cur_q.len - off_q - cnt_q};
					end else begin
						waddr = IdxBits'(idx_q + 2'd2);
						wdata = '{orig: cur_q.orig, off: cur_q.off + off_q,
							len: cur_q.len - off_q};
					end
					need_d = 2'd3;
				end else if (need_q == 2'd3) begin
					waddr = idx_q[IdxBits-1:0];
					wdata = '{orig: cur_q.orig, off: cur_q.off, len: off_q};
					need_d = (op_q == OP_ERASE) ? 2'd0 : 2'd1;
					idx_d = (op_q == OP_ERASE) ? idx_q : idx_q + 1'b1;
					if (op_q == OP_ERASE) begin
						state_d = S_FIX;
					end
				end else begin
					waddr = idx_q[IdxBits-1:0];
					wdata = '{orig: 1'b0, off: fill_q, len: cnt_q};
					state_d = S_FIX;
				end
			end
			S_FIX: begin
				count_d = count_q + gap_q;
				if (op_q == OP_INSERT) begin
					if (need_q == 2'd0 && gap_q == '0) begin
						count_d = count_q;
					end
					fill_d = fill_q + cnt_q;
					total_d = total_q + cnt_q;
				end else begin
					count_d = count_q + 1'b1;
					total_d = total_q - cnt_q;
				end
				gap_d = '0;
				res_d.document_length = total_d;
				state_d = S_RESULT;
			end
			S_ER_EV: begin
				if (idx_q >= count_q) begin
					rst_d = ST_POS;
					res_d.status = ST_POS;
					state_d = S_RESULT;
				end else if (off_q != '0) begin
					if (cnt_q < cur_q.len - off_q) begin
						if (32'(count_q) + 32'd1 > 32'(MaxPieces)) begin
							rst_d = ST_FULL;
							res_d.status = ST_FULL;
							state_d = S_RESULT;
						end else begin
							gap_d = CntBits'(1);
							k_d = idx_q + 1'b1;
							need_d = 2'd2;
							ptr_d = count_q;
							state_d = S_SH_RD;
						end
					end else begin
						we = 1'b1;
						waddr = idx_q[IdxBits-1:0];
						wdata = '{orig: cur_q.orig, off: cur_q.off, len: off_q};
						rem_d = cnt_q - (cur_q.len - off_q);
						idx_d = idx_q + 1'b1;
						k_d = idx_q + 1'b1;
						ptr_d = idx_q + 1'b1;
						state_d = S_ER_RD;
					end
				end else begin
					k_d = idx_q;
					ptr_d = idx_q;
					state_d = S_ER_RD;
				end
			end
			S_ER_RD: begin
				if (rem_q == '0 || k_q >= count_q) begin
					ptr_d = k_q;
					gap_d = k_q - idx_q;
					state_d = S_CL_RD;
				end else begin
					raddr = k_q[IdxBits-1:0];
					state_d = S_ER_WT;
				end
			end
			S_ER_WT: begin
				if (rem_q >= rdata.len) begin
					rem_d = rem_q - rdata.len;
					k_d = k_q + 1'b1;
					state_d = S_ER_RD;
				end else begin
					ptr_d = k_q;
					gap_d = k_q - idx_q;
					state_d = S_CL_RD;
				end
			end
			S_CL_RD: begin
				if (gap_q == '0 || ptr_q >= count_q) begin
					count_d = count_q - gap_q;
					gap_d = '0;
					state_d = S_TRIM_RD;
				end else begin
					raddr = ptr_q[IdxBits-1:0];
					state_d = S_CL_WT;
				end
			end
			S_CL_WT: state_d = S_CL_WR;
			S_CL_WR: begin
				we = 1'b1;
				waddr = IdxBits'(ptr_q - gap_q);
				wdata = rdata;
				ptr_d = ptr_q + 1'b1;
				state_d = S_CL_RD;
			end
			S_TRIM_RD: begin
				raddr = idx_q[IdxBits-1:0];
				if (rem_q != '0 && idx_q < count_q) begin
					state_d = S_TRIM_WT;
				end else begin
					total_d = total_q - cnt_q;
					res_d.document_length = total_d;
					state_d = S_RESULT;
				end
			end
			S_TRIM_WT: begin
				raddr = idx_q[IdxBits-1:0];
				state_d = S_TRIM_WR;
			end
			S_TRIM_WR: begin
				we = 1'b1;
				waddr = idx_q[IdxBits-1:0];
				wdata = '{orig: rdata.orig, off: rdata.off + rem_q, len: rdata.len - rem_q};
				total_d = total_q - cnt_q;
				res_d.document_length = total_d;
				state_d = S_RESULT;
			end
			S_RD_RD: begin
				raddr = idx_q[IdxBits-1:0];
				state_d = S_RD_WT;
			end
			S_RD_WT: begin
				seg_w = rdata.len - off_q;
				if (seg_w > rem_q) begin
					seg_w = rem_q;
				end
				rem_d = rem_q - seg_w;
				res_d = '{status: ST_OK, from_add_buffer: !rdata.orig,
					source_offset: rdata.off + off_q, segment_length: seg_w,
					document_length: total_q, last: (rem_d == '0)};
				off_d = '0;
				idx_d = idx_q + 1'b1;
				state_d = S_RD_EM;
			end
			S_RD_EM: begin
				if (!(out_valid && !out_ready)) begin
					if (res_q.last) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_RD_RD;
					end
				end
			end
			S_RESULT: begin
				if (!(out_valid && !out_ready)) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_LOC_EV && op_q == OP_INSERT) begin
			raddr = IdxBits'(idx_q - 1'b1);
		end
		if (state_q == S_LOC_RD) begin
			raddr = ptr_q[IdxBits-1:0];
		end
	end
endmodule

@@ rtl/ptde_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module ptde_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/ptde_checker.sv @@
// Port-level checks for the piece table descriptor engine, bound to the top level.
// Depends on ptde_pkg.
module ptde_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input ptde_pkg::out_item_t out_data
);
	import ptde_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("item taken while result pending");
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready straight after an item was taken");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.last)
		else $error("error result not last");
	a_seg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.segment_length == '0)
		else $error("error result carries segment");
endmodule

bind piece_table_descriptor_engine ptde_checker u_ptde_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
